// ===== sv/bhx_pkg.sv =====
package bhx_pkg;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_DATA   = 2'd1;
  localparam logic [1:0] CMD_CRC    = 2'd2;
  localparam logic [1:0] CMD_FINISH = 2'd3;

  localparam logic [1:0] CFG_NEWLINE_LEN    = 2'd0;
  localparam logic [1:0] CFG_NEWLINE_FIRST  = 2'd1;
  localparam logic [1:0] CFG_NEWLINE_SECOND = 2'd2;

  localparam logic [7:0]  ESCAPE_BYTE = 8'h90;
  localparam logic [7:0]  COLON_CHAR  = 8'h3a;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  localparam logic [7:0] ALPHABET [64] = '{
    8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28,
    8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h30, 8'h31, 8'h32,
    8'h33, 8'h34, 8'h35, 8'h36, 8'h38, 8'h39, 8'h40, 8'h41,
    8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
    8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h50, 8'h51, 8'h52,
    8'h53, 8'h54, 8'h55, 8'h56, 8'h58, 8'h59, 8'h5a, 8'h5b,
    8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h68,
    8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h70, 8'h71, 8'h72
  };

  typedef enum logic [1:0] {
    JOB_CHAR,
    JOB_COLON,
    JOB_START
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [5:0] six;
    logic       last;
  } job_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_START,
    FS_CRCA,
    FS_CRCB,
    FS_BYTE,
    FS_CLOSE
  } front_state_t;

  typedef enum logic [1:0] {
    BK_JOB,
    BK_BRK1,
    BK_BRK2
  } back_state_t;

  // augmented CRC-16: shift the data bit in at the bottom
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] c);
    logic [15:0] acc;
    logic        msb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      msb = acc[15];
      acc = {acc[14:0], c[i]};
      if (msb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

endpackage

// ===== sv/bhx_fifo.sv =====
module bhx_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bhx_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output bhx_pkg::job_t pop_job,
  output logic          empty
);
  import bhx_pkg::*;

  job_t       slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full    = (count == 3'd4);
  assign empty   = (count == 3'd0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {2'b0, push && !full} - {2'b0, pop && !empty};
    end
  end

endmodule

// ===== sv/bhx_front.sv =====
module bhx_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    cmd,
  input  logic [7:0]    data_byte,
  output logic          job_valid,
  output bhx_pkg::job_t job,
  input  logic          job_full
);
  import bhx_pkg::*;

  front_state_t state, state_next;
  logic [7:0]   cur, cur_next;
  logic [7:0]   second, second_next;
  logic         have_second, have_second_next;
  logic         part2, part2_next;
  logic         in_esc, in_esc_next;
  logic         feed, feed_next;
  logic         close_pend, close_pend_next;
  logic [1:0]   phase, phase_next;
  logic [5:0]   carry_bits, carry_bits_next;
  logic [15:0]  crc, crc_next;

  logic        push;
  logic        byte_done;
  logic        escape_next;
  logic        item_done;
  logic        accept;
  logic [15:0] snap;

  assign push      = job_valid && !job_full;
  assign item_done = push && job.last;
  assign in_stall  = !((state == FS_IDLE) || item_done);
  assign accept    = in_valid && !in_stall;
  assign snap      = crc_feed(crc, 8'h00);

  always_comb begin
    state_next       = state;
    cur_next         = cur;
    second_next      = second;
    have_second_next = have_second;
    part2_next       = part2;
    in_esc_next      = in_esc;
    feed_next        = feed;
    close_pend_next  = close_pend;
    phase_next       = phase;
    carry_bits_next  = carry_bits;
    crc_next         = crc;
    job_valid        = 1'b0;
    job.kind         = JOB_CHAR;
    job.six          = '0;
    job.last         = 1'b0;
    byte_done        = 1'b0;
    escape_next      = 1'b0;

    unique case (state)
      FS_IDLE: begin
      end
      FS_START: begin
        job_valid = 1'b1;
        job.kind  = JOB_START;
        job.last  = 1'b1;
        if (!job_full) begin
          crc_next        = '0;
          phase_next      = 2'd0;
          carry_bits_next = '0;
          state_next      = FS_IDLE;
        end
      end
      FS_CRCA: begin
        crc_next   = snap;
        state_next = FS_CRCB;
      end
      FS_CRCB: begin
        cur_next         = snap[15:8];
        second_next      = snap[7:0];
        have_second_next = 1'b1;
        feed_next        = 1'b0;
        in_esc_next      = 1'b0;
        part2_next       = 1'b0;
        close_pend_next  = 1'b0;
        crc_next         = '0;
        state_next       = FS_BYTE;
      end
      FS_BYTE: begin
        job_valid = 1'b1;
        if (part2) begin
          job.six   = cur[5:0];
          byte_done = 1'b1;
        end else if (phase == 2'd1) begin
          job.six   = carry_bits | {2'b0, cur[7:4]};
          byte_done = 1'b1;
        end else if (phase == 2'd2) begin
          job.six = carry_bits | {4'b0, cur[7:6]};
        end else begin
          job.six   = cur[7:2];
          byte_done = 1'b1;
        end
        escape_next = byte_done && (cur == ESCAPE_BYTE) && !in_esc;
        job.last    = byte_done && !escape_next && !have_second && !close_pend;

        if (!job_full) begin
          if (part2) begin
            part2_next      = 1'b0;
            phase_next      = 2'd0;
            carry_bits_next = '0;
          end else if (phase == 2'd1) begin
            phase_next      = 2'd2;
            carry_bits_next = {cur[3:0], 2'b0};
          end else if (phase == 2'd2) begin
            part2_next = 1'b1;
          end else begin
            phase_next      = 2'd1;
            carry_bits_next = {cur[1:0], 4'b0};
          end

          if (byte_done) begin
            if (feed && !in_esc) begin
              crc_next = crc_feed(crc, cur);
            end
            if (escape_next) begin
              cur_next    = 8'h00;
              in_esc_next = 1'b1;
            end else if (have_second) begin
              cur_next         = second;
              have_second_next = 1'b0;
              in_esc_next      = 1'b0;
            end else if (close_pend) begin
              close_pend_next = 1'b0;
              state_next      = FS_CLOSE;
            end else begin
              state_next = FS_IDLE;
            end
          end
        end
      end
      FS_CLOSE: begin
        job_valid = 1'b1;
        job.kind  = JOB_COLON;
        job.last  = 1'b1;
        if (!job_full) begin
          state_next = FS_IDLE;
        end
      end
      default: begin
        state_next = FS_IDLE;
      end
    endcase

    // load the next command over whatever the finished one left
    if (accept) begin
      unique case (cmd)
        CMD_START: begin
          state_next = FS_START;
        end
        CMD_DATA: begin
          cur_next         = data_byte;
          feed_next        = 1'b1;
          in_esc_next      = 1'b0;
          part2_next       = 1'b0;
          have_second_next = 1'b0;
          close_pend_next  = 1'b0;
          state_next       = FS_BYTE;
        end
        CMD_CRC: begin
          state_next = FS_CRCA;
        end
        CMD_FINISH: begin
          if (phase_next == 2'd1 || phase_next == 2'd2) begin
            cur_next         = 8'h00;
            feed_next        = 1'b1;
            in_esc_next      = 1'b0;
            part2_next       = 1'b0;
            have_second_next = 1'b0;
            close_pend_next  = 1'b1;
            state_next       = FS_BYTE;
          end else begin
            state_next = FS_CLOSE;
          end
        end
        default: begin
          state_next = FS_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= FS_IDLE;
      have_second <= 1'b0;
      part2       <= 1'b0;
      in_esc      <= 1'b0;
      feed        <= 1'b0;
      close_pend  <= 1'b0;
      phase       <= 2'd0;
      carry_bits  <= '0;
      crc         <= '0;
    end else begin
      state       <= state_next;
      have_second <= have_second_next;
      part2       <= part2_next;
      in_esc      <= in_esc_next;
      feed        <= feed_next;
      close_pend  <= close_pend_next;
      phase       <= phase_next;
      carry_bits  <= carry_bits_next;
      crc         <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    cur    <= cur_next;
    second <= second_next;
  end

endmodule

// ===== sv/bhx_back.sv =====
module bhx_back #(
  parameter int unsigned LINE_WIDTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  input  logic          job_empty,
  input  bhx_pkg::job_t job,
  output logic          job_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_char,
  output logic          last
);
  import bhx_pkg::*;

  localparam logic [6:0] LineWidthW = 7'(LINE_WIDTH);

  back_state_t state, state_next;
  logic [6:0]  line_count, line_count_next;
  logic        brk_last, brk_last_next;
  logic [1:0]  newline_len;
  logic [7:0]  newline_first;
  logic [7:0]  newline_second;

  logic [1:0] len_eff;
  logic       adv;
  logic       produce;
  logic [7:0] char_next;
  logic       last_next;
  logic [6:0] count_inc;

  assign len_eff   = (newline_len == 2'd3) ? 2'd2 : newline_len;
  assign adv       = !out_valid || !out_stall;
  assign count_inc = line_count + 7'd1;

  always_comb begin
    state_next      = state;
    line_count_next = line_count;
    brk_last_next   = brk_last;
    job_pop         = 1'b0;
    produce         = 1'b0;
    char_next       = out_char;
    last_next       = last;

    unique case (state)
      BK_JOB: begin
        if (adv && !job_empty) begin
          job_pop = 1'b1;
          unique case (job.kind)
            JOB_CHAR: begin
              produce   = 1'b1;
              char_next = ALPHABET[job.six];
              last_next = job.last;
              if (count_inc == LineWidthW) begin
                line_count_next = '0;
                if (len_eff != 2'd0) begin
                  last_next     = 1'b0;
                  brk_last_next = job.last;
                  state_next    = BK_BRK1;
                end
              end else begin
                line_count_next = count_inc;
              end
            end
            JOB_COLON: begin
              produce   = 1'b1;
              char_next = COLON_CHAR;
              last_next = job.last;
              if (len_eff != 2'd0) begin
                last_next     = 1'b0;
                brk_last_next = job.last;
                state_next    = BK_BRK1;
              end
            end
            JOB_START: begin
              line_count_next = 7'd1;
            end
            default: begin
            end
          endcase
        end
      end
      BK_BRK1: begin
        if (adv) begin
          produce   = 1'b1;
          char_next = newline_first;
          if (len_eff == 2'd2) begin
            last_next  = 1'b0;
            state_next = BK_BRK2;
          end else begin
            last_next  = brk_last;
            state_next = BK_JOB;
          end
        end
      end
      BK_BRK2: begin
        if (adv) begin
          produce    = 1'b1;
          char_next  = newline_second;
          last_next  = brk_last;
          state_next = BK_JOB;
        end
      end
      default: begin
        state_next = BK_JOB;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_JOB;
      line_count <= 7'd1;
      brk_last   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      line_count <= line_count_next;
      brk_last   <= brk_last_next;
      if (adv) begin
        out_valid <= produce;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && produce) begin
      out_char <= char_next;
      last     <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newline_len    <= 2'd1;
      newline_first  <= 8'd13;
      newline_second <= 8'd10;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_NEWLINE_LEN:    newline_len    <= cfg_data[1:0];
        CFG_NEWLINE_FIRST:  newline_first  <= cfg_data;
        CFG_NEWLINE_SECOND: newline_second <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/binhex_stream_encoder.sv =====
// channel  direction  handshake            payload
// cfg      in         cfg_write            cfg_index, cfg_data
// in       in         in_valid / in_stall  cmd, data_byte
// out      out        out_valid / out_stall out_char, last
//
// The output register gives one character per cycle while not stalled; a line
// break of up to two characters follows a full line and the closing colon. The
// front emits a job per encoded 6-bit group (the 0x00 after an escaped byte
// included), one on start and a colon on finish; emit-CRC feeds two zero bytes.
// A four-deep job queue lets the front take the next command while the back
// drains. Synchronous active-high reset; out_stall holds the beat and backs up.
module binhex_stream_encoder #(
  parameter int unsigned LINE_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       last
);
  import bhx_pkg::*;

  job_t push_job;
  job_t pop_job;
  logic push;
  logic full;
  logic pop;
  logic empty;

  bhx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .data_byte (data_byte),
    .job_valid (push),
    .job       (push_job),
    .job_full  (full)
  );

  bhx_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  bhx_back #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_empty (empty),
    .job       (pop_job),
    .job_pop   (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last      (last)
  );

endmodule
